// File: hdl/mbrtu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus RTU read unit.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

	localparam int FRAME_MAX = 256;
	localparam int REGS_MAX  = 128;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  EXC_BIT   = 8'h80;
	localparam logic [8:0]  MIN_REPLY = 9'd5;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_END   = 2'd2,
		REQ_NONE  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_WORD   = 2'd1,
		KIND_STATUS = 2'd2
	} out_kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_ADDR  = 3'd2,
		ST_FUNC  = 3'd3,
		ST_EXC   = 3'd4,
		ST_CRC   = 3'd5
	} status_t;

	typedef struct packed {
		logic clear;
		logic byte_go;
		logic end_go;
	} rx_ctl_t;

	typedef struct packed {
		logic        word_valid;
		logic [15:0] word_value;
		logic [6:0]  word_index;
		status_t     status;
		logic [7:0]  exception_code;
		logic [6:0]  registers_read;
	} rx_res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hdl/mbrtu_rx_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_rx_parse
// Reply parser: tracks position, running CRC and verdict, yields register
// words as data pairs complete and the final status on an end request.
// ----------------------------------------------------------------------------
module mbrtu_rx_parse
	import mbrtu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rx_ctl_t     ctl,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  held_slave,
	input  wire logic [7:0]  held_function,
	input  wire logic [15:0] held_count,
	output rx_res_t          res
);

	logic [8:0]  rx_pos_q;
	logic [7:0]  data_len_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_low_q;
	logic [7:0]  high_byte_q;
	status_t     frame_status_q;
	logic [7:0]  exception_q;
	logic [6:0]  words_q;

	logic [8:0]  data_end;
	logic [8:0]  d;
	logic [6:0]  idx;
	logic        in_range;
	logic        live;
	logic        in_data;
	logic        in_lim;
	logic [15:0] crc_next;
	logic [8:0]  need;

	assign data_end = 9'd3 + {1'b0, data_len_q};
	assign d        = rx_pos_q - 9'd3;
	assign idx      = d[7:1];
	assign in_range = rx_pos_q < 9'(FRAME_MAX);
	assign live     = (frame_status_q == ST_OK) || (frame_status_q == ST_CRC);
	assign in_data  = (rx_pos_q >= 9'd3) && (rx_pos_q < data_end) && live && in_range;
	assign in_lim   = (idx < data_len_q[7:1]) && ({9'd0, idx} < held_count)
		&& ({1'b0, idx} < 8'(REGS_MAX));
	assign crc_next = crc_byte(crc_q, rx_byte);
	assign need     = MIN_REPLY + {1'b0, data_len_q};

	always_comb begin
		res.word_valid     = in_data && d[0] && in_lim;
		res.word_value     = {high_byte_q, rx_byte};
		res.word_index     = idx;
		res.exception_code = 8'h00;
		res.registers_read = 7'd0;
		if (rx_pos_q < MIN_REPLY) begin
			res.status = ST_SHORT;
		end else if (frame_status_q == ST_ADDR || frame_status_q == ST_FUNC) begin
			res.status = frame_status_q;
		end else if (frame_status_q == ST_EXC) begin
			res.status         = ST_EXC;
			res.exception_code = exception_q;
		end else if (rx_pos_q < need) begin
			res.status = ST_SHORT;
		end else if (frame_status_q == ST_CRC) begin
			res.status = ST_CRC;
		end else begin
			res.status         = ST_OK;
			res.registers_read = words_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_pos_q       <= 9'd0;
			data_len_q     <= 8'd0;
			crc_q          <= CRC_INIT;
			crc_low_q      <= 8'd0;
			high_byte_q    <= 8'd0;
			frame_status_q <= ST_SHORT;
			exception_q    <= 8'd0;
			words_q        <= 7'd0;
		end else if (ctl.clear || ctl.end_go) begin
			rx_pos_q       <= 9'd0;
			data_len_q     <= 8'd0;
			crc_q          <= CRC_INIT;
			crc_low_q      <= 8'd0;
			high_byte_q    <= 8'd0;
			frame_status_q <= ST_SHORT;
			exception_q    <= 8'd0;
			words_q        <= 7'd0;
		end else if (ctl.byte_go && in_range) begin
			rx_pos_q <= rx_pos_q + 9'd1;
			if (rx_pos_q == 9'd0) begin
				frame_status_q <= (rx_byte == held_slave) ? ST_OK : ST_ADDR;
				crc_q          <= crc_next;
			end else if (rx_pos_q == 9'd1) begin
				if (frame_status_q == ST_OK) begin
					if (rx_byte == held_function || rx_byte == (held_function | EXC_BIT)) begin
						frame_status_q <= rx_byte[7] ? ST_EXC : ST_OK;
					end else begin
						frame_status_q <= ST_FUNC;
					end
				end
				crc_q <= crc_next;
			end else if (rx_pos_q == 9'd2) begin
				if (frame_status_q == ST_EXC) begin
					exception_q <= rx_byte;
				end else begin
					data_len_q <= rx_byte;
				end
				crc_q <= crc_next;
			end else if (live) begin
				if (rx_pos_q < data_end) begin
					crc_q <= crc_next;
					if (!d[0]) begin
						high_byte_q <= rx_byte;
					end else if (in_lim) begin
						words_q <= (idx == 7'd127) ? 7'd127 : idx + 7'd1;
					end
				end else if (rx_pos_q == data_end) begin
					crc_low_q <= rx_byte;
				end else if (rx_pos_q == data_end + 9'd1) begin
					frame_status_q <= ({rx_byte, crc_low_q} == crc_q) ? ST_OK : ST_CRC;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/modbus_rtu_read_transaction_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_read_transaction_unit
// Modbus RTU master read transaction: builds the request frame with CRC and
// parses the streamed reply into register words and a final status.
// ----------------------------------------------------------------------------
// channel  dir  tdata bits                     tuser         tlast
// s_*      in   request fields, 56 bits        req_type      -
// m_*      out  result fields, 56 bits         out_kind      last
//
// Reply byte and end requests leave the input register at once, so one
// request is accepted every cycle unless a result waits on a full output
// register. A start request holds it while the byte counter steps the CRC
// and sends the eight request bytes. One output register parts the two sides.
// Reset clears all control and receive state; the CRC restarts at 0xFFFF.
// ----------------------------------------------------------------------------
module modbus_rtu_read_transaction_unit
	import mbrtu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// slave_address, function_code, first_register, wanted_count, rx_byte
	input  wire logic [55:0] s_tdata,
	// req_type
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tx_byte, register_value, register_index, status, exception_code,
	// registers_read, pad
	output logic [55:0]      m_tdata,
	// out_kind
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	logic        valid_s1;
	req_type_t   type_s1;
	logic [55:0] data_s1;

	logic [3:0]  tx_pos_q;
	logic [15:0] tx_crc_q;
	logic [7:0]  held_slave_q;
	logic [7:0]  held_function_q;
	logic [15:0] held_count_q;

	logic        o_valid_q;
	out_kind_t   o_kind_q;
	logic [7:0]  o_tx_q;
	logic [15:0] o_val_q;
	logic [6:0]  o_idx_q;
	status_t     o_st_q;
	logic [7:0]  o_exc_q;
	logic [6:0]  o_rd_q;
	logic        o_last_q;

	logic        out_free;
	logic        s1_done;
	logic        o_load;
	logic [7:0]  tx_byte;
	logic [15:0] crc_base;
	rx_ctl_t     rx_ctl;
	rx_res_t     rx_res;

	assign out_free = !o_valid_q || m_tready;
	assign crc_base = (tx_pos_q == 4'd0) ? CRC_INIT : tx_crc_q;

	always_comb begin
		case (tx_pos_q)
			4'd0:    tx_byte = data_s1[7:0];
			4'd1:    tx_byte = data_s1[15:8];
			4'd2:    tx_byte = data_s1[31:24];
			4'd3:    tx_byte = data_s1[23:16];
			4'd4:    tx_byte = data_s1[47:40];
			4'd5:    tx_byte = data_s1[39:32];
			4'd6:    tx_byte = tx_crc_q[7:0];
			default: tx_byte = tx_crc_q[15:8];
		endcase
	end

	always_comb begin
		s1_done = 1'b0;
		o_load  = 1'b0;
		rx_ctl  = '0;
		if (valid_s1) begin
			case (type_s1)
				REQ_START: begin
					o_load       = out_free;
					s1_done      = out_free && (tx_pos_q == 4'd7);
					rx_ctl.clear = out_free && (tx_pos_q == 4'd0);
				end
				REQ_BYTE: begin
					o_load         = out_free && rx_res.word_valid;
					s1_done        = out_free || !rx_res.word_valid;
					rx_ctl.byte_go = s1_done;
				end
				REQ_END: begin
					o_load        = out_free;
					s1_done       = out_free;
					rx_ctl.end_go = out_free;
				end
				default: s1_done = 1'b1;
			endcase
		end
	end

	assign s_tready = !valid_s1 || s1_done;

	mbrtu_rx_parse u_rx (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (rx_ctl),
		.rx_byte       (data_s1[55:48]),
		.held_slave    (held_slave_q),
		.held_function (held_function_q),
		.held_count    (held_count_q),
		.res           (rx_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			type_s1         <= REQ_NONE;
			tx_pos_q        <= 4'd0;
			tx_crc_q        <= CRC_INIT;
			held_slave_q    <= 8'd0;
			held_function_q <= 8'd0;
			held_count_q    <= 16'd0;
			o_valid_q       <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
				type_s1  <= req_type_t'(s_tuser);
			end
			if (valid_s1 && type_s1 == REQ_START && out_free) begin
				tx_pos_q <= (tx_pos_q == 4'd7) ? 4'd0 : tx_pos_q + 4'd1;
				if (tx_pos_q < 4'd6) begin
					tx_crc_q <= crc_byte(crc_base, tx_byte);
				end
				if (tx_pos_q == 4'd0) begin
					held_slave_q    <= data_s1[7:0];
					held_function_q <= data_s1[15:8];
					held_count_q    <= data_s1[47:32];
				end
			end
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			data_s1 <= s_tdata;
		end
		if (o_load) begin
			o_tx_q   <= 8'd0;
			o_val_q  <= 16'd0;
			o_idx_q  <= 7'd0;
			o_st_q   <= ST_OK;
			o_exc_q  <= 8'd0;
			o_rd_q   <= 7'd0;
			o_last_q <= 1'b0;
			case (type_s1)
				REQ_START: begin
					o_kind_q <= KIND_TX;
					o_tx_q   <= tx_byte;
					o_last_q <= (tx_pos_q == 4'd7);
				end
				REQ_BYTE: begin
					o_kind_q <= KIND_WORD;
					o_val_q  <= rx_res.word_value;
					o_idx_q  <= rx_res.word_index;
				end
				default: begin
					o_kind_q <= KIND_STATUS;
					o_st_q   <= rx_res.status;
					o_exc_q  <= rx_res.exception_code;
					o_rd_q   <= rx_res.registers_read;
					o_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {7'd0, o_rd_q, o_exc_q, o_st_q, o_idx_q, o_val_q, o_tx_q};

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU read transaction unit. Start, reply
// byte and end requests are driven with random gaps and the results are
// accepted with random stalls. A predictor built into the monitor tracks the
// held request and the reply parser, and each accepted result is compared
// with the oldest expected one. Replies are mostly well-formed frames with
// valid CRC, mixed with exceptions, wrong address or function, bad CRC,
// truncated and overlong frames, restarts and noise.
// ----------------------------------------------------------------------------
module testbench;
	import mbrtu_pkg::*;

	localparam int FLAW_NONE = 0;
	localparam int FLAW_CRC  = 1;
	localparam int FLAW_CUT  = 2;
	localparam int FLAW_TAIL = 3;

	typedef struct {
		req_type_t   kind;
		logic [7:0]  slave;
		logic [7:0]  func;
		logic [15:0] first;
		logic [15:0] count;
		logic [7:0]  rxb;
	} mb_req_t;

	typedef struct packed {
		out_kind_t   kind;
		logic [7:0]  tx;
		logic [15:0] value;
		logic [6:0]  index;
		status_t     status;
		logic [7:0]  exc;
		logic [6:0]  nread;
		logic        last;
	} mb_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = REQ_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	mb_req_t pending[$];
	mb_res_t expected[$];
	mb_req_t next_req;
	int      items_total = 0;
	int      items_sent = 0;
	int      items_accepted = 0;
	int      results_seen = 0;
	int      errors = 0;
	int      gap_left = 0;
	int      stall_left = 0;
	int      stall;

	// predictor state
	logic [7:0]  hold_slave;
	logic [7:0]  hold_func;
	logic [15:0] hold_count;
	int unsigned rx_pos;
	logic [7:0]  data_len;
	logic [15:0] rx_crc;
	logic [7:0]  crc_lo;
	logic [7:0]  data_hi;
	status_t     rx_status;
	logic [7:0]  exc_code;
	logic [6:0]  words_out;

	modbus_rtu_read_transaction_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[k];
			c = c >> 1;
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// ---------------- predictor ----------------

	task automatic rx_reset();
		rx_pos = 0;
		data_len = '0;
		rx_crc = CRC_INIT;
		crc_lo = '0;
		data_hi = '0;
		rx_status = ST_SHORT;
		exc_code = '0;
		words_out = '0;
	endtask

	task automatic push_result(input out_kind_t kind, input logic [7:0] tx,
			input logic [15:0] value, input logic [6:0] index, input status_t st,
			input logic [7:0] exc, input logic [6:0] nread, input logic last);
		mb_res_t r;
		r.kind = kind;
		r.tx = tx;
		r.value = value;
		r.index = index;
		r.status = st;
		r.exc = exc;
		r.nread = nread;
		r.last = last;
		expected.push_back(r);
	endtask

	task automatic model_start(input mb_req_t r);
		logic [7:0]  frame [8];
		logic [15:0] crc;
		hold_slave = r.slave;
		hold_func = r.func;
		hold_count = r.count;
		rx_reset();
		frame[0] = r.slave;
		frame[1] = r.func;
		frame[2] = r.first[15:8];
		frame[3] = r.first[7:0];
		frame[4] = r.count[15:8];
		frame[5] = r.count[7:0];
		crc = CRC_INIT;
		for (int i = 0; i < 6; i++) crc = crc16_step(crc, frame[i]);
		frame[6] = crc[7:0];
		frame[7] = crc[15:8];
		for (int i = 0; i < 8; i++)
			push_result(KIND_TX, frame[i], '0, '0, ST_OK, '0, '0, i == 7);
	endtask

	task automatic model_byte(input logic [7:0] b);
		int unsigned pos;
		int unsigned data_end;
		int unsigned d;
		int unsigned idx;
		int unsigned lim;
		pos = rx_pos;
		data_end = 3 + data_len;
		if (pos >= FRAME_MAX) return;
		rx_pos = pos + 1;
		if (pos == 0) begin
			rx_status = (b == hold_slave) ? ST_OK : ST_ADDR;
			rx_crc = crc16_step(rx_crc, b);
		end else if (pos == 1) begin
			if (rx_status == ST_OK) begin
				if (b == hold_func || b == (hold_func | EXC_BIT))
					rx_status = b[7] ? ST_EXC : ST_OK;
				else
					rx_status = ST_FUNC;
			end
			rx_crc = crc16_step(rx_crc, b);
		end else if (pos == 2) begin
			if (rx_status == ST_EXC) exc_code = b;
			else data_len = b;
			rx_crc = crc16_step(rx_crc, b);
		end else if (rx_status != ST_OK && rx_status != ST_CRC) begin
		end else if (pos < data_end) begin
			d = pos - 3;
			rx_crc = crc16_step(rx_crc, b);
			if (d % 2 == 0) begin
				data_hi = b;
			end else begin
				idx = d / 2;
				lim = data_len / 2;
				if (hold_count < lim) lim = hold_count;
				if (REGS_MAX < lim) lim = REGS_MAX;
				if (idx < lim) begin
					push_result(KIND_WORD, '0, {data_hi, b}, idx[6:0], ST_OK, '0, '0, 1'b0);
					words_out = (idx + 1 > 127) ? 7'd127 : 7'(idx + 1);
				end
			end
		end else if (pos == data_end) begin
			crc_lo = b;
		end else if (pos == data_end + 1) begin
			rx_status = ({b, crc_lo} == rx_crc) ? ST_OK : ST_CRC;
		end
	endtask

	task automatic model_end();
		status_t    st;
		logic [7:0] exc;
		logic [6:0] nread;
		exc = '0;
		nread = '0;
		if (rx_pos < MIN_REPLY) begin
			st = ST_SHORT;
		end else if (rx_status == ST_ADDR || rx_status == ST_FUNC) begin
			st = rx_status;
		end else if (rx_status == ST_EXC) begin
			st = ST_EXC;
			exc = exc_code;
		end else if (rx_pos < MIN_REPLY + data_len) begin
			st = ST_SHORT;
		end else if (rx_status == ST_CRC) begin
			st = ST_CRC;
		end else begin
			st = ST_OK;
			nread = words_out;
		end
		push_result(KIND_STATUS, '0, '0, '0, st, exc, nread, 1'b1);
		rx_reset();
	endtask

	task automatic model_request(input mb_req_t r);
		case (r.kind)
			REQ_START: model_start(r);
			REQ_BYTE:  model_byte(r.rxb);
			REQ_END:   model_end();
			default: ;
		endcase
	endtask

	// ---------------- stimulus ----------------

	function automatic mb_req_t random_req(input req_type_t kind);
		mb_req_t r;
		r.kind = kind;
		r.slave = 8'($urandom);
		r.func = 8'($urandom);
		r.first = 16'($urandom);
		r.count = 16'($urandom);
		r.rxb = 8'($urandom);
		return r;
	endfunction

	task automatic queue_req(input mb_req_t r);
		pending.push_back(r);
		items_total++;
	endtask

	task automatic queue_start(input logic [7:0] slv, input logic [7:0] fn,
			input logic [15:0] first, input logic [15:0] cnt);
		mb_req_t r;
		r = random_req(REQ_START);
		r.slave = slv;
		r.func = fn;
		r.first = first;
		r.count = cnt;
		queue_req(r);
	endtask

	task automatic queue_byte(input logic [7:0] b);
		mb_req_t r;
		r = random_req(REQ_BYTE);
		r.rxb = b;
		queue_req(r);
	endtask

	task automatic queue_reply(input logic [7:0] slv, input logic [7:0] fn,
			input logic [7:0] bc, input int ndata, input int flaw);
		logic [7:0]  frame[$];
		logic [15:0] crc;
		int          cut;
		frame.push_back(slv);
		frame.push_back(fn);
		frame.push_back(bc);
		repeat (ndata) frame.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (frame[i]) crc = crc16_step(crc, frame[i]);
		if (flaw == FLAW_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
		if (flaw == FLAW_CUT) begin
			cut = $urandom_range(1, frame.size());
			repeat (cut) void'(frame.pop_back());
		end
		if (flaw == FLAW_TAIL) repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
		foreach (frame[i]) queue_byte(frame[i]);
		queue_req(random_req(REQ_END));
	endtask

	task automatic build_stimulus();
		logic [7:0] cur_slave;
		logic [7:0] cur_func;
		logic [7:0] bc;
		int         sel;
		int         flaw;

		queue_req('{REQ_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF});
		queue_req(random_req(REQ_END));
		queue_start(8'h00, 8'h00, 16'h0000, 16'h0000);
		queue_start(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		queue_reply(8'hFF, 8'hFF, 8'h0B, 0, FLAW_NONE);
		queue_start(8'h11, 8'h03, 16'h006B, 16'h0002);
		queue_reply(8'h11, 8'h03, 8'd6, 6, FLAW_NONE);
		cur_slave = 8'h11;
		cur_func = 8'h03;

		while (items_total < 150) begin
			sel = $urandom_range(0, 99);
			if (sel < 70 && $urandom_range(0, 9) < 7) begin
				cur_slave = 8'($urandom);
				cur_func = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(3, 4));
				queue_start(cur_slave, cur_func, 16'($urandom),
					($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12)));
			end
			if (sel < 60) begin
				bc = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 24)) :
					8'(2 * $urandom_range(0, 8));
				case ($urandom_range(0, 9))
					0: flaw = FLAW_CRC;
					1: flaw = FLAW_CUT;
					2: flaw = FLAW_TAIL;
					default: flaw = FLAW_NONE;
				endcase
				queue_reply(cur_slave, cur_func, bc, bc, flaw);
			end else if (sel < 70) begin
				queue_reply(cur_slave, cur_func | EXC_BIT, 8'($urandom), 0,
					($urandom_range(0, 3) == 0) ? FLAW_CRC : FLAW_NONE);
			end else if (sel < 78) begin
				bc = 8'(2 * $urandom_range(0, 4));
				queue_reply(cur_slave ^ 8'($urandom_range(1, 255)), cur_func, bc, bc, FLAW_NONE);
			end else if (sel < 86) begin
				bc = 8'(2 * $urandom_range(0, 4));
				queue_reply(cur_slave, cur_func ^ 8'($urandom_range(1, 127)), bc, bc, FLAW_NONE);
			end else if (sel < 92) begin
				queue_start(cur_slave, cur_func, 16'($urandom), 16'($urandom_range(0, 12)));
				repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
				queue_start(cur_slave, cur_func, 16'($urandom), 16'($urandom_range(0, 12)));
				bc = 8'(2 * $urandom_range(0, 6));
				queue_reply(cur_slave, cur_func, bc, bc, FLAW_NONE);
			end else if (sel < 96) begin
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 4) == 0) queue_req(random_req(REQ_NONE));
					else queue_byte(8'($urandom));
				end
				queue_req(random_req(REQ_END));
			end else begin
				if ($urandom_range(0, 1) == 0) queue_req(random_req(REQ_NONE));
				queue_req(random_req(REQ_END));
			end
		end

		// largest frame that fits with trailing bytes past the buffer, then a
		// byte count too large to fit
		queue_start(8'h5A, 8'h04, 16'($urandom), 16'hFFFF);
		queue_reply(8'h5A, 8'h04, 8'd251, 251, FLAW_TAIL);
		queue_reply(8'h5A, 8'h04, 8'd255, 0, FLAW_NONE);
	endtask

	// ---------------- driver ----------------

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending.size() != 0) begin
				next_req = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_req.kind;
				s_tdata <= {next_req.rxb, next_req.count, next_req.first,
					next_req.func, next_req.slave};
				gap_left <= ((items_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 7);
				items_sent++;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------

	task automatic report_error(input string what, input mb_res_t got, input mb_res_t want);
		errors++;
		if (errors <= 10) begin
			$display("%s: got kind=%0d tx=%02h val=%04h idx=%0d st=%0d exc=%02h rd=%0d last=%0b",
				what, got.kind, got.tx, got.value, got.index, got.status, got.exc,
				got.nread, got.last);
			$display("  want kind=%0d tx=%02h val=%04h idx=%0d st=%0d exc=%02h rd=%0d last=%0b",
				want.kind, want.tx, want.value, want.index, want.status, want.exc,
				want.nread, want.last);
		end
	endtask

	task automatic check_result();
		mb_res_t got;
		mb_res_t want;
		got.kind = out_kind_t'(m_tuser);
		got.tx = m_tdata[7:0];
		got.value = m_tdata[23:8];
		got.index = m_tdata[30:24];
		got.status = status_t'(m_tdata[33:31]);
		got.exc = m_tdata[41:34];
		got.nread = m_tdata[48:42];
		got.last = m_tlast;
		if (expected.size() == 0) begin
			want = '0;
			report_error("unexpected result", got, want);
		end else begin
			want = expected.pop_front();
			if (got !== want) report_error("mismatch", got, want);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
				results_seen++;
				stall = ((results_seen / 40) % 4 == 1) ? 0 : $urandom_range(0, 7);
				m_tready <= (stall == 0);
				stall_left <= stall;
			end else if (!m_tready) begin
				if (stall_left <= 1) m_tready <= 1'b1;
				if (stall_left > 0) stall_left <= stall_left - 1;
			end
			if (s_tvalid && s_tready) begin
				model_request('{req_type_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
					s_tdata[31:16], s_tdata[47:32], s_tdata[55:48]});
				items_accepted++;
			end
		end
	end

	// ---------------- sequencing ----------------

	initial begin
		hold_slave = '0;
		hold_func = '0;
		hold_count = '0;
		rx_reset();
		build_stimulus();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (items_accepted == items_total);
		while (expected.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
